// ===== rtl/emrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package emrs_pkg;

  localparam int DIST_W    = 32;
  localparam int RATIO_W   = 16;
  localparam int CNT_CFG_W = 11;
  localparam int IDX_OUT_W = 10;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int PROD_W    = DIST_W + RATIO_W;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  // match status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPT      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW_SAMPLES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FEW_VALID   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RATIO_FAIL  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATIO       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_DIV     = 2'd3;

  localparam logic [RATIO_W-1:0]   RATIO_RST       = 16'd52429;
  localparam logic [CNT_CFG_W-1:0] MIN_SAMPLES_RST = 11'd18;
  localparam logic [CNT_CFG_W-1:0] MIN_VALID_RST   = 11'd8;
  localparam logic [CNT_CFG_W-1:0] WIN_DIV_RST     = 11'd10;

  typedef struct packed {
    logic upd;
    logic check;
    logic div_start;
    logic win_load;
    logic scan;
    logic mul;
    logic cmp;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reject;
    logic div_done;
    logic scan_done;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/emrs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module emrs_div
  import emrs_pkg::*;
#(
  parameter int CW = 11
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [CW-1:0]        dividend_i,
  input  wire logic [CNT_CFG_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [CW-1:0]             quotient_o
);

  localparam int CNTW = $clog2(CW + 1);

  logic [CNTW-1:0]      cnt_q;
  logic [CW-1:0]        quo_q;
  logic [CNT_CFG_W-1:0] rem_q;
  logic [CNT_CFG_W:0]   rem_sh;
  logic                 fits;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_q, quo_q[CW-1]};
  assign fits   = rem_sh >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(CW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[CW-2:0], fits};
      rem_q <= fits ? CNT_CFG_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[CNT_CFG_W-1:0];
    end
  end

  assign done_o     = cnt_q == '0;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/emrs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module emrs_dp
  import emrs_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [DIST_W-1:0]    sample_distance_i,
  input  wire logic                 sample_valid_i,
  input  wire ctrl_cmd_t            cmd_i,
  output dp_status_t                status_o,
  output logic [STATUS_W-1:0]       match_status_o,
  output logic [IDX_OUT_W-1:0]      best_index_o,
  output logic [DIST_W-1:0]         best_distance_o,
  output logic [DIST_W-1:0]         second_distance_o
);

  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int CMPW = (CW > CNT_CFG_W) ? CW : CNT_CFG_W;
  localparam int WINW = CW + 1;
  localparam int IDXW = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;

  logic [RATIO_W-1:0]   ratio_q;
  logic [CNT_CFG_W-1:0] min_samples_q;
  logic [CNT_CFG_W-1:0] min_valid_q;
  logic [CNT_CFG_W-1:0] win_div_q;

  logic [CW-1:0]     count_q;
  logic [CW-1:0]     vcount_q;
  logic [AW-1:0]     best_pos_q;
  logic [DIST_W-1:0] best_val_q;

  logic [DIST_W-1:0] mem [MAX_SAMPLES];
  logic [DIST_W-1:0] rdata_q;
  logic              rd_vld_q;
  logic              rd_skip_q;
  logic [CW-1:0]     scan_idx_q;
  logic [WINW-1:0]   lo_q;
  logic [WINW-1:0]   hi_q;
  logic [DIST_W-1:0] second_q;
  logic [PROD_W-1:0] prod_q;
  logic [STATUS_W-1:0] status_q;

  logic [STATUS_W-1:0] out_status_q;
  logic [AW-1:0]       out_idx_q;
  logic [DIST_W-1:0]   out_best_q;
  logic [DIST_W-1:0]   out_second_q;

  logic                 store_en;
  logic                 rd_en;
  logic                 skip;
  logic                 few_samples;
  logic                 few_valid;
  logic [CNT_CFG_W-1:0] divisor;
  logic [CW-1:0]        quotient;
  logic [CW-1:0]        half;
  logic [WINW-1:0]      best_ext;
  logic [WINW-1:0]      half_ext;
  logic [PROD_W-1:0]    prod_d;
  logic [PROD_W-1:0]    best_sh;
  logic [IDXW-1:0]      idx_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q       <= RATIO_RST;
      min_samples_q <= MIN_SAMPLES_RST;
      min_valid_q   <= MIN_VALID_RST;
      win_div_q     <= WIN_DIV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RATIO:       ratio_q       <= cfg_data_i;
        REG_MIN_SAMPLES: min_samples_q <= cfg_data_i[CNT_CFG_W-1:0];
        REG_MIN_VALID:   min_valid_q   <= cfg_data_i[CNT_CFG_W-1:0];
        REG_WIN_DIV:     win_div_q     <= cfg_data_i[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // line state; samples past the store depth are dropped
  assign store_en = cmd_i.upd && (count_q < CW'(MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      vcount_q   <= '0;
      best_pos_q <= '0;
      best_val_q <= DIST_ONES;
    end else if (cmd_i.load_out) begin
      count_q    <= '0;
      vcount_q   <= '0;
      best_pos_q <= '0;
      best_val_q <= DIST_ONES;
    end else if (store_en) begin
      count_q <= count_q + 1'b1;
      if (sample_valid_i) begin
        vcount_q <= vcount_q + 1'b1;
        if (sample_distance_i < best_val_q) begin
          best_val_q <= sample_distance_i;
          best_pos_q <= count_q[AW-1:0];
        end
      end
    end
  end

  // distance store
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[count_q[AW-1:0]] <= sample_valid_i ? sample_distance_i : DIST_ONES;
    end
    if (rd_en) begin
      rdata_q <= mem[scan_idx_q[AW-1:0]];
    end
  end

  assign few_samples = CMPW'(count_q) < CMPW'(min_samples_q);
  assign few_valid   = CMPW'(vcount_q) < CMPW'(min_valid_q);
  assign divisor     = (win_div_q == '0) ? CNT_CFG_W'(1) : win_div_q;

  emrs_div #(
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (count_q),
    .divisor_i  (divisor),
    .done_o     (status_o.div_done),
    .quotient_o (quotient)
  );

  // suppression window is [best - half, best + half]
  assign half     = quotient >> 1;
  assign best_ext = WINW'(best_pos_q);
  assign half_ext = WINW'(half);

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_load) begin
      lo_q <= (best_ext >= half_ext) ? (best_ext - half_ext) : '0;
      hi_q <= best_ext + half_ext;
    end
  end

  assign rd_en = cmd_i.scan && (scan_idx_q < count_q);
  assign skip  = (WINW'(scan_idx_q) >= lo_q) && (WINW'(scan_idx_q) <= hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      scan_idx_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.win_load) begin
        scan_idx_q <= '0;
      end else if (rd_en) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end
  end

  assign prod_d  = PROD_W'(ratio_q) * PROD_W'(second_q);
  assign best_sh = {best_val_q, {RATIO_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_skip_q <= skip;
    end
    if (cmd_i.check) begin
      second_q <= DIST_ONES;
      status_q <= few_samples ? ST_FEW_SAMPLES : ST_FEW_VALID;
    end else if (rd_vld_q && !rd_skip_q && (rdata_q < second_q)) begin
      second_q <= rdata_q;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.cmp) begin
      status_q <= (best_sh < prod_q) ? ST_ACCEPT : ST_RATIO_FAIL;
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_idx_q    <= best_pos_q;
      out_best_q   <= best_val_q;
      out_second_q <= second_q;
    end
  end

  assign status_o.reject    = few_samples || few_valid;
  assign status_o.scan_done = (scan_idx_q == count_q) && !rd_vld_q;

  assign idx_ext           = IDXW'(out_idx_q);
  assign match_status_o    = out_status_q;
  assign best_index_o      = idx_ext[IDX_OUT_W-1:0];
  assign best_distance_o   = out_best_q;
  assign second_distance_o = out_second_q;

endmodule
`default_nettype wire

// ===== rtl/emrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module emrs_ctrl
  import emrs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       last_sample_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_WIN   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.upd = in_valid_i;
        if (in_valid_i && last_sample_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.reject) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_WIN;
      end
      S_WIN: begin
        cmd_o.win_load = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/epipolar_match_ratio_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Epipolar match ratio selector. Distances of one epipolar line stream in one word per
// cycle while the block is idle and are kept in an on-chip store of MAX_SAMPLES entries;
// the first strict minimum is tracked on the fly. The word flagged last_sample closes the
// line: the block then stops taking input while it checks the counts, divides the sample
// count by window_divisor with a bit-serial divider, places the suppression window, scans
// the store through its single read port for the second best, runs the 16x32 ratio
// multiply and compare and loads the result register. A rejected line skips the divide,
// scan, multiply and compare. The result register lets the next line stream in while a
// result waits to be taken.
module epipolar_match_ratio_selector
  import emrs_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [DIST_W-1:0]    sample_distance_i,
  input  wire logic                 sample_valid_i,
  input  wire logic                 last_sample_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [STATUS_W-1:0]       match_status_o,
  output logic [IDX_OUT_W-1:0]      best_index_o,
  output logic [DIST_W-1:0]         best_distance_o,
  output logic [DIST_W-1:0]         second_distance_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  emrs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  emrs_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .sample_distance_i (sample_distance_i),
    .sample_valid_i    (sample_valid_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .match_status_o    (match_status_o),
    .best_index_o      (best_index_o),
    .best_distance_o   (best_distance_o),
    .second_distance_o (second_distance_o)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import emrs_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int LONG_HOLD  = 3000;
  localparam int RUN_LIMIT  = 600000;
  localparam int SETTLE     = 40;
  localparam int DRAIN      = 100;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] index;
    logic [DIST_W-1:0]    best;
    logic [DIST_W-1:0]    second;
  } match_t;

  class line_match_tracker;
    logic [RATIO_W-1:0]   ratio;
    logic [CNT_CFG_W-1:0] need_samples;
    logic [CNT_CFG_W-1:0] need_valid;
    logic [CNT_CFG_W-1:0] win_div;
    logic [DIST_W-1:0]    line_dist [LINE_DEPTH];
    int unsigned          n_samples;
    int unsigned          n_valid;
    int unsigned          best_pos;
    logic [DIST_W-1:0]    best_val;
    match_t               expected_matches [$];
    int unsigned          n_words;
    int unsigned          n_lines;
    int unsigned          n_errors;
    int unsigned          n_status [4];

    function new();
      ratio        = RATIO_RST;
      need_samples = MIN_SAMPLES_RST;
      need_valid   = MIN_VALID_RST;
      win_div      = WIN_DIV_RST;
      n_words      = 0;
      n_lines      = 0;
      n_errors     = 0;
      foreach (n_status[s]) n_status[s] = 0;
      start_line();
    endfunction

    function void start_line();
      n_samples = 0;
      n_valid   = 0;
      best_pos  = 0;
      best_val  = DIST_ONES;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_RATIO:       ratio        = data[RATIO_W-1:0];
        REG_MIN_SAMPLES: need_samples = data[CNT_CFG_W-1:0];
        REG_MIN_VALID:   need_valid   = data[CNT_CFG_W-1:0];
        REG_WIN_DIV:     win_div      = data[CNT_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [DIST_W-1:0] word_dist, logic in_border, logic closes);
      int unsigned div;
      int unsigned half;
      longint unsigned lhs;
      longint unsigned rhs;
      match_t exp;
      n_words++;
      // samples past the store depth are dropped, but a last marker still counts
      if (n_samples < LINE_DEPTH) begin
        line_dist[n_samples] = in_border ? word_dist : DIST_ONES;
        if (in_border) begin
          n_valid++;
          if (word_dist < best_val) begin
            best_val = word_dist;
            best_pos = n_samples;
          end
        end
        n_samples++;
      end
      if (!closes) return;
      exp.index  = best_pos[IDX_OUT_W-1:0];
      exp.best   = best_val;
      exp.second = DIST_ONES;
      if (n_samples < need_samples) begin
        exp.status = ST_FEW_SAMPLES;
      end else if (n_valid < need_valid) begin
        exp.status = ST_FEW_VALID;
      end else begin
        div  = (win_div == 0) ? 1 : win_div;
        half = (n_samples / div) / 2;
        // everything within half of the minimum (itself included) is masked
        for (int unsigned i = 0; i < n_samples; i++) begin
          if ((i + half < best_pos || i > best_pos + half) && line_dist[i] < exp.second)
            exp.second = line_dist[i];
        end
        lhs = 64'(best_val) << 16;
        rhs = 64'(ratio) * 64'(exp.second);
        exp.status = (lhs < rhs) ? ST_ACCEPT : ST_RATIO_FAIL;
      end
      expected_matches = {expected_matches, exp};
      start_line();
    endfunction

    function void check_match(match_t got);
      match_t exp;
      if (expected_matches.size() == 0) begin
        $error("result word with no line pending: status %0d index %0d", got.status, got.index);
        n_errors++;
        return;
      end
      exp = expected_matches.pop_front();
      n_lines++;
      n_status[got.status]++;
      if (got.status !== exp.status) begin
        $error("match_status: expected %0d, got %0d", exp.status, got.status);
        n_errors++;
      end
      if (got.index !== exp.index) begin
        $error("best_index: expected %0d, got %0d", exp.index, got.index);
        n_errors++;
      end
      if (got.best !== exp.best) begin
        $error("best_distance: expected %h, got %h", exp.best, got.best);
        n_errors++;
      end
      if (got.second !== exp.second) begin
        $error("second_distance: expected %h, got %h", exp.second, got.second);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i       = REG_RATIO;
  logic [CFG_W-1:0]     cfg_data_i        = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_ready_o;
  logic [DIST_W-1:0]    sample_distance_i = '0;
  logic                 sample_valid_i    = 1'b0;
  logic                 last_sample_i     = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i       = 1'b0;
  logic [STATUS_W-1:0]  match_status_o;
  logic [IDX_OUT_W-1:0] best_index_o;
  logic [DIST_W-1:0]    best_distance_o;
  logic [DIST_W-1:0]    second_distance_o;

  line_match_tracker tracker;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  epipolar_match_ratio_selector u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_distance_i (sample_distance_i),
    .sample_valid_i    (sample_valid_i),
    .last_sample_i     (last_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .match_status_o    (match_status_o),
    .best_index_o      (best_index_o),
    .best_distance_o   (best_distance_o),
    .second_distance_o (second_distance_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: take words, then decide next cycle's ready
  always @(posedge clk_i) begin : result_side
    match_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = match_status_o;
      got.index  = best_index_o;
      got.best   = best_distance_o;
      got.second = second_distance_o;
      tracker.check_match(got);
    end
    if (hold_seen != hold_token) begin
      hold_seen   <= hold_token;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(logic [DIST_W-1:0] word_dist, logic in_border, logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_distance_i <= word_dist;
    sample_valid_i    <= in_border;
    last_sample_i     <= closes;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_sample(word_dist, in_border, closes);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.expected_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    tracker.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [CFG_W-1:0] ratio, logic [CFG_W-1:0] n_min,
                             logic [CFG_W-1:0] v_min, logic [CFG_W-1:0] div);
    write_reg(REG_RATIO, ratio);
    write_reg(REG_MIN_SAMPLES, n_min);
    write_reg(REG_MIN_VALID, v_min);
    write_reg(REG_WIN_DIV, div);
    cfg_we_i <= 1'b0;
  endtask

  // a line around a common level with one planted low sample and some outliers
  task automatic send_line(int len, int plant, int valid_pct);
    logic [DIST_W-1:0] level;
    logic [DIST_W-1:0] spread;
    logic [DIST_W-1:0] word_dist;
    logic [63:0]       sum;
    case ($urandom_range(3))
      0:       level = $urandom_range(0, 255);
      1:       level = $urandom_range(0, 65535) << 8;
      2:       level = $urandom >> 1;
      default: level = $urandom;
    endcase
    spread = level >> $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(19))
        0:       word_dist = $urandom;
        1:       word_dist = DIST_ONES;
        2:       word_dist = '0;
        default: begin
          sum       = 64'(level) + 64'($urandom_range(0, spread));
          word_dist = (sum > 64'(DIST_ONES)) ? DIST_ONES : sum[DIST_W-1:0];
        end
      endcase
      if (i == plant) begin
        sum       = (64'(level) * 64'($urandom_range(0, 1023))) >> 10;
        word_dist = sum[DIST_W-1:0];
      end
      send_word(word_dist, $urandom_range(99) < valid_pct, i == len - 1);
    end
  endtask

  task automatic run_phase(int words, int idle, int stall, bit hold);
    int sent;
    int len;
    int pick;
    int valid_pct;
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) hold_token++;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(99);
      if (pick < 85)      len = $urandom_range(1, 40);
      else if (pick < 98) len = $urandom_range(41, 150);
      else                len = $urandom_range(151, 400);
      case ($urandom_range(4))
        0:       valid_pct = 15;
        1:       valid_pct = 60;
        2:       valid_pct = 95;
        default: valid_pct = 100;
      endcase
      send_line(len, $urandom_range(0, len - 1), valid_pct);
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: two samples is too short a line
    send_word('0, 1'b1, 1'b0);
    send_word(DIST_ONES, 1'b1, 1'b1);
    wait_idle();

    // zero thresholds always pass, zero divisor acts as one, widest ratio
    load_config(16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_word('0, 1'b1, 1'b1);
    // no valid minimum at all
    send_word(32'h0000_1234, 1'b0, 1'b0);
    send_word('0, 1'b0, 1'b0);
    send_word(DIST_ONES, 1'b0, 1'b0);
    send_word(32'd5, 1'b0, 1'b1);
    // tie on the minimum keeps the first one
    send_word(32'd10, 1'b1, 1'b0);
    send_word(32'd5, 1'b1, 1'b0);
    send_word(32'd5, 1'b1, 1'b0);
    send_word(DIST_ONES, 1'b1, 1'b0);
    send_word(32'd7, 1'b0, 1'b1);
    wait_idle();

    // zero ratio never accepts, largest divisor
    load_config(16'd0, 16'd1, 16'd3, 16'h07FF);
    send_word(32'd3, 1'b1, 1'b0);
    send_word(32'd1, 1'b0, 1'b0);
    send_word(32'd2, 1'b1, 1'b1);
    send_word(32'd100, 1'b1, 1'b0);
    send_word(32'd1, 1'b1, 1'b0);
    send_word(32'd50, 1'b1, 1'b0);
    send_word(32'd200, 1'b1, 1'b1);
    wait_idle();

    load_config(RATIO_RST, CFG_W'(MIN_SAMPLES_RST), CFG_W'(MIN_VALID_RST),
                CFG_W'(WIN_DIV_RST));
    run_phase(160, 0, 0, 1'b0);
    load_config(16'hFFFF, 16'd1, 16'd1, 16'd1);
    run_phase(160, 74, 0, 1'b0);
    load_config(16'd40000, 16'd5, 16'd3, 16'd3);
    run_phase(160, 0, 74, 1'b0);
    load_config(CFG_W'($urandom), CFG_W'($urandom_range(0, 24)),
                CFG_W'($urandom_range(0, 16)), CFG_W'($urandom_range(0, 12)));
    run_phase(160, 22, 22, 1'b0);
    // result side holds off while lines keep coming
    load_config(RATIO_RST, 16'd4, 16'd2, 16'd2047);
    run_phase(160, 0, 0, 1'b1);

    // one line past the store depth, closed by a dropped sample
    load_config(16'd32768, 16'd1024, 16'd600, 16'd4);
    send_idle_pct = 0;
    stall_pct     = 0;
    send_line(1030, $urandom_range(900, 1023), 100);
    wait_idle();

    // upper data bits on the count registers are ignored
    load_config(16'h8000 | 16'($urandom_range(0, 32767)), 16'hF80C, 16'hF803, 16'hF802);
    run_phase(160, 22, 22, 1'b0);

    repeat (DRAIN) @(posedge clk_i);
    $display("%0d samples over %0d lines, %0d result mismatches",
             tracker.n_words, tracker.n_lines, tracker.n_errors);
    $display("accepted %0d, too few samples %0d, too few valid %0d, ratio failed %0d",
             tracker.n_status[ST_ACCEPT], tracker.n_status[ST_FEW_SAMPLES],
             tracker.n_status[ST_FEW_VALID], tracker.n_status[ST_RATIO_FAIL]);
    if (tracker.n_errors == 0 && tracker.expected_matches.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
